// ===== rtl/swmv_pkg.sv =====
// ----------------------------------------------------------------------------
// swmv_pkg
// shared constants and types of the sliding window mode vote block
// ----------------------------------------------------------------------------
package swmv_pkg;

  // samples held in the window
  localparam int WINDOW = 8;

  // field widths
  localparam int FC_W  = 5;
  localparam int CFG_W = 4;

  // threshold after reset
  localparam logic [CFG_W-1:0] MIN_COUNT_RESET = 4'd4;

  // fill level and hit counter hold 0..WINDOW
  localparam int CNT_W = $clog2(WINDOW + 1);
  // scan position counters hold 0..WINDOW-1
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // width used to compare hits against the threshold
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // operation on the window taps
  typedef struct packed {
    logic shift;   // push a new sample, drop the oldest
    logic rotate;  // circular move by one toward the head
  } win_op_t;

  // finished result from the sequencer
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [FC_W-1:0] value;
  } vote_res_t;

endpackage

// ===== rtl/sliding_window_mode_vote.sv =====
// Timing: while the window fills, a beat goes from the input straight to the
//   done state; once it is full, each candidate is scanned over the rotating window.
// Pacing: a new beat is taken only after the result of the last has entered
//   the output register, since one comparator serves the scan of each candidate.
// Reset: rst synchronous active high, clears fill level and output valid,
//   min_count returns to 4; window samples are not cleared.
// ----------------------------------------------------------------------------
// sliding_window_mode_vote
// majority vote over the last samples of a stream of finger counts
// ----------------------------------------------------------------------------
module sliding_window_mode_vote (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,    // min_count
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // [4:0] finger_count, [7:5] zero
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // [4:0] mode_value, [7:5] zero
  output logic [0:0] m_tuser       // [0] found
);

  logic [swmv_pkg::CFG_W-1:0] min_count;
  logic [swmv_pkg::FC_W-1:0]  head;
  logic                       out_free;
  logic                       found_q;
  logic [swmv_pkg::FC_W-1:0]  value_q;
  swmv_pkg::win_op_t          op;
  swmv_pkg::vote_res_t        res;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_count <= swmv_pkg::MIN_COUNT_RESET;
    end else if (cfg_we) begin
      min_count <= cfg_wdata;
    end
  end

  swmv_window u_window (
    .clk    (clk),
    .op     (op),
    .sample (s_tdata[swmv_pkg::FC_W-1:0]),
    .head   (head)
  );

  swmv_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_free  (out_free),
    .min_count (min_count),
    .head      (head),
    .op        (op),
    .res       (res)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      found_q <= res.found;
      value_q <= res.value;
    end
  end

  assign m_tdata = {{(8 - swmv_pkg::FC_W){1'b0}}, value_q};
  assign m_tuser = found_q;

endmodule

// ===== rtl/swmv_window.sv =====
// ----------------------------------------------------------------------------
// swmv_window
// shift line of the last samples, oldest at the head, with circular rotate
// ----------------------------------------------------------------------------
module swmv_window (
  input  logic                    clk,
  input  swmv_pkg::win_op_t       op,
  input  logic [swmv_pkg::FC_W-1:0] sample,
  output logic [swmv_pkg::FC_W-1:0] head
);

  logic [swmv_pkg::FC_W-1:0] taps [swmv_pkg::WINDOW];

  // push or rotate the taps
  always_ff @(posedge clk) begin
    if (op.shift) begin
      for (int k = 0; k < swmv_pkg::WINDOW - 1; k++) begin
        taps[k] <= taps[k+1];
      end
      taps[swmv_pkg::WINDOW-1] <= sample;
    end else if (op.rotate) begin
      for (int k = 0; k < swmv_pkg::WINDOW - 1; k++) begin
        taps[k] <= taps[k+1];
      end
      taps[swmv_pkg::WINDOW-1] <= taps[0];
    end
  end

  assign head = taps[0];

endmodule

// ===== rtl/swmv_seq.sv =====
// ----------------------------------------------------------------------------
// swmv_seq
// sequencer: fill tracking, candidate scan with one shared comparator
// ----------------------------------------------------------------------------
module swmv_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       out_free,
  input  logic [swmv_pkg::CFG_W-1:0] min_count,
  input  logic [swmv_pkg::FC_W-1:0]  head,
  output swmv_pkg::win_op_t          op,
  output swmv_pkg::vote_res_t        res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAND = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [swmv_pkg::IDX_W-1:0] LAST_IDX = swmv_pkg::IDX_W'(swmv_pkg::WINDOW - 1);
  localparam logic [swmv_pkg::CNT_W-1:0] FULL_LVL = swmv_pkg::CNT_W'(swmv_pkg::WINDOW);
  localparam logic [swmv_pkg::CNT_W-1:0] PRE_FULL = swmv_pkg::CNT_W'(swmv_pkg::WINDOW - 1);

  logic [2:0]                     state;
  logic [swmv_pkg::CNT_W-1:0]     fill;
  logic [swmv_pkg::FC_W-1:0]      cand;
  logic [swmv_pkg::CNT_W-1:0]     hits;
  logic [swmv_pkg::IDX_W-1:0]     inner;
  logic [swmv_pkg::IDX_W-1:0]     outer;
  logic                           found;
  logic [swmv_pkg::FC_W-1:0]      value;

  logic                           accept;
  logic                           match;
  logic [swmv_pkg::CNT_W-1:0]     hits_next;
  logic                           over_thr;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_ready && in_valid;

  // shared compare unit and hit count
  assign match     = (head == cand);
  assign hits_next = hits + swmv_pkg::CNT_W'(match);
  assign over_thr  = swmv_pkg::CMP_W'(hits_next) > swmv_pkg::CMP_W'(min_count);

  // window control
  assign op.shift  = accept;
  assign op.rotate = (state == S_SCAN) || (state == S_STEP);

  // result toward the output register
  assign res.valid = (state == S_DONE);
  assign res.found = found;
  assign res.value = value;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            found <= 1'b0;
            value <= '0;
            outer <= '0;
            if (fill != FULL_LVL) begin
              fill <= fill + swmv_pkg::CNT_W'(1);
            end
            state <= (fill >= PRE_FULL) ? S_CAND : S_DONE;
          end
        end
        S_CAND: begin
          cand  <= head;
          hits  <= '0;
          inner <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          hits  <= hits_next;
          inner <= inner + swmv_pkg::IDX_W'(1);
          if (inner == LAST_IDX) begin
            // first qualifying candidate, oldest first, wins
            if (!found && over_thr) begin
              found <= 1'b1;
              value <= cand;
            end
            state <= S_STEP;
          end
        end
        S_STEP: begin
          outer <= outer + swmv_pkg::IDX_W'(1);
          state <= (outer == LAST_IDX) ? S_DONE : S_CAND;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/swmv_checker.sv =====
// ----------------------------------------------------------------------------
// swmv_checker
// port level checks of the mode vote block, bound to the top level
// ----------------------------------------------------------------------------
module swmv_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // no decision reports a zero value
  a_no_decision_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
    else $error("value nonzero without decision");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:5] == 3'd0)
    else $error("padding bits of result set");

  // block is busy in the cycle after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken back to back");

endmodule

bind sliding_window_mode_vote swmv_checker u_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for sliding_window_mode_vote: finger counts go in as
// beats, a scoreboard keeps its own window and vote and checks every result
// beat in order, over several thresholds and idling mixes
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 183;
  localparam int RING_DEPTH     = 16;

  // one decision of the vote
  typedef struct packed {
    logic                      found;
    logic [swmv_pkg::FC_W-1:0] value;
  } vote_t;

  // keeps a copy of the window and the threshold, rings the decision
  // for every accepted sample and compares result beats against it
  class vote_scoreboard;
    logic [swmv_pkg::FC_W-1:0]  samples [swmv_pkg::WINDOW];
    int                         fill;
    logic [swmv_pkg::CFG_W-1:0] threshold;
    vote_t                      ring [RING_DEPTH];
    int                         wr_ptr;
    int                         rd_ptr;
    int                         count;
    int                         errors;

    function new();
      fill      = 0;
      threshold = swmv_pkg::MIN_COUNT_RESET;
      wr_ptr    = 0;
      rd_ptr    = 0;
      count     = 0;
      errors    = 0;
    endfunction

    function void set_threshold(logic [swmv_pkg::CFG_W-1:0] thr);
      threshold = thr;
    endfunction

    function int pending();
      return count;
    endfunction

    function void note_sample(logic [swmv_pkg::FC_W-1:0] fc);
      vote_t d;
      int    hits;
      d = '0;
      if (fill < swmv_pkg::WINDOW - 1) begin
        samples[fill] = fc;
        fill++;
      end else begin
        samples[swmv_pkg::WINDOW-1] = fc;
        // oldest candidate first; first one over the threshold wins
        for (int i = 0; i < swmv_pkg::WINDOW && !d.found; i++) begin
          hits = 0;
          for (int j = 0; j < swmv_pkg::WINDOW; j++)
            if (samples[j] == samples[i]) hits++;
          if (hits > int'(threshold)) begin
            d.found = 1'b1;
            d.value = samples[i];
          end
        end
        for (int i = 0; i < swmv_pkg::WINDOW - 1; i++)
          samples[i] = samples[i+1];
      end
      if (count == RING_DEPTH) begin
        errors++;
        if (errors <= 10)
          $display("too many decisions outstanding at %0t", $realtime);
      end else begin
        ring[wr_ptr] = d;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        count++;
      end
    endfunction

    function void check_result(logic found, logic [swmv_pkg::FC_W-1:0] value);
      vote_t d;
      if (count == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: found %0b value %0d", found, value);
        return;
      end
      d = ring[rd_ptr];
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      count--;
      if (found !== d.found || value !== d.value) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: expected found %0b value %0d, got found %0b value %0d",
                   $realtime, d.found, d.value, found, value);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [swmv_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata = '0;     // [4:0] finger_count, [7:5] zero
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [7:0]                 m_tdata;          // [4:0] mode_value, [7:5] zero
  logic [0:0]                 m_tuser;          // [0] found

  vote_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  // random sample source: mostly a favorite and a rival value so that
  // full windows reach the threshold often, the rest uniform noise
  logic [swmv_pkg::FC_W-1:0] favorite = '0;
  logic [swmv_pkg::FC_W-1:0] rival    = '1;

  sliding_window_mode_vote dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // idling mix by mode: none, sender, receiver, both
  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // offer one sample beat; valid is left high after acceptance so the
  // next call or the caller decides its value in that same step
  task automatic send_sample(input logic [swmv_pkg::FC_W-1:0] fc);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, fc};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(fc);
  endtask

  // stop offering and wait until every queued decision has come back
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // threshold write, only while the block is idle
  task automatic write_threshold(input logic [swmv_pkg::CFG_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    sb.set_threshold(thr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [swmv_pkg::FC_W-1:0] next_sample();
    int r;
    if ($urandom_range(99) < 8) favorite = swmv_pkg::FC_W'($urandom_range(31));
    if ($urandom_range(99) < 5) rival = swmv_pkg::FC_W'($urandom_range(31));
    r = $urandom_range(99);
    if (r < 55) return favorite;
    if (r < 75) return rival;
    return swmv_pkg::FC_W'($urandom_range(31));
  endfunction

  // result side: check beats, random stalls, long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tuser[0], m_tdata[swmv_pkg::FC_W-1:0]);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // main sequence
  initial begin : stimulus
    logic [swmv_pkg::CFG_W-1:0] thresholds [PHASE_COUNT];
    thresholds = '{4'd4, 4'd2, 4'd8, 4'd0, 4'd3, 4'd15, 4'd5, 4'd1, 4'd6, 4'd7};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(0);

    // reset threshold: window fills with no decision, then one value wins
    send_sample(5'd31);
    send_sample(5'd0);
    send_sample(5'd21);
    send_sample(5'd10);
    send_sample(5'd31);
    send_sample(5'd31);
    send_sample(5'd31);
    send_sample(5'd31);
    repeat (5) send_sample(5'd0);
    wait_results_drained();

    // zero threshold: the oldest sample always wins
    write_threshold(4'd0);
    send_sample(5'd5);
    send_sample(5'd9);
    wait_results_drained();

    // threshold at or above the window length never decides
    write_threshold(4'd8);
    send_sample(5'd3);
    wait_results_drained();
    write_threshold(4'd15);
    send_sample(5'd3);
    wait_results_drained();

    // one below the window: only a uniform window decides
    write_threshold(4'd7);
    repeat (8) send_sample(5'd17);
    wait_results_drained();

    // random phases over thresholds and idling mixes
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_threshold(thresholds[p]);
      set_idling(p % 4);
      // result side held off while samples keep coming
      if (p == 4) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_sample(next_sample());
        // sender pause until all results are back
        if (p == 6 && k == PHASE_ITEMS / 2) wait_results_drained();
      end
      wait_results_drained();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/swmv_pkg.sv
rtl/swmv_window.sv
rtl/swmv_seq.sv
rtl/sliding_window_mode_vote.sv
rtl/swmv_checker.sv
tb/tb.sv
